### design/vcpt_pkg.sv
// Shared types, constants and tables for the vocoder carrier pitch tracker.
package vcpt_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int PERIOD_INT_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 36;
    localparam int DIV_C_W = 6;

    localparam logic [23:0] STEP_MAX    = 24'hFFFFFF;
    localparam int          OFFSET_Q23  = 251658;
    localparam int          NOISE_SCALE = 5497558;
    localparam int          SIXTENTHS   = 39322;
    localparam int          ROOT_K      = 12989;
    localparam int          ET_RECIP    = 3355444;
    localparam int          ET_SHIFT    = 25;
    localparam logic [15:0] LFSR_TAPS   = 16'hB400;
    localparam logic [15:0] LFSR_SEED   = 16'hACE1;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dvd;
        logic [DIV_D_W-1:0] dvs;
        logic [DIV_C_W-1:0] last;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quo;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [16:0] semi_ratio(input logic [3:0] n);
        case (n)
            4'd0:    return 17'd65536;
            4'd1:    return 17'd69433;
            4'd2:    return 17'd73562;
            4'd3:    return 17'd77936;
            4'd4:    return 17'd82570;
            4'd5:    return 17'd87480;
            4'd6:    return 17'd92682;
            4'd7:    return 17'd98193;
            4'd8:    return 17'd104032;
            4'd9:    return 17'd110218;
            4'd10:   return 17'd116772;
            4'd11:   return 17'd123715;
            default: return 17'd65536;
        endcase
    endfunction

    function automatic logic [16:0] semi_bound(input logic [3:0] n);
        case (n)
            4'd0:    return 17'd67456;
            4'd1:    return 17'd71468;
            4'd2:    return 17'd75717;
            4'd3:    return 17'd80220;
            4'd4:    return 17'd84990;
            4'd5:    return 17'd90043;
            4'd6:    return 17'd95398;
            4'd7:    return 17'd101070;
            4'd8:    return 17'd107080;
            4'd9:    return 17'd113448;
            4'd10:   return 17'd120194;
            4'd11:   return 17'd127341;
            default: return 17'd127341;
        endcase
    endfunction

    function automatic logic [3:0] semi_index(input logic [16:0] m);
        logic [3:0] n;
        n = '0;
        for (int j = 0; j < 12; j++) begin
            if (m >= semi_bound(4'(j))) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

endpackage

### design/vocoder_carrier_pitch_tracker.sv
// Top level: sequencer, filter and tracker state, carrier output register.
//
//   channel | valid        | ready        | payload
//   --------+--------------+--------------+---------------------------------
//   in      | i_in_valid   | o_in_ready   | i_voice_sample
//   out     | o_out_valid  | i_out_ready  | o_voice_out, o_carrier_out
//   cfg     | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Each word takes seven to nine passes (start, one step per multiplier bit, handoff)
// through the shared serial multiplier; on an accepted pitch crossing one more
// multiply and two restoring divides, plus a further divide, a normalize and two
// more multiplies in quantized mode.
// Reset is synchronous; there is no clearing pass. Results sit in an output
// register, so a stalled output holds the finished word while the next is taken.
module vocoder_carrier_pitch_tracker #(
    parameter int SAMPLE_BITS     = vcpt_pkg::SAMPLE_BITS_DEF,
    parameter int PERIOD_INT_BITS = vcpt_pkg::PERIOD_INT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [SAMPLE_BITS-1:0]           i_voice_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [SAMPLE_BITS-1:0]           o_voice_out,
    output logic [SAMPLE_BITS-1:0]           o_carrier_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vcpt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vcpt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import vcpt_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PW = PERIOD_INT_BITS + 8;
    localparam int CW = (PW > 20) ? PW : 20;
    localparam logic [PW-1:0] PMAX = '1;
    localparam logic signed [28:0] CAR_MAX = 29'((64'(1) << (SB - 1)) - 1);
    localparam logic signed [28:0] CAR_MIN = -CAR_MAX - 29'sd1;

    localparam logic [1:0] MODE_FIXED = 2'd0;
    localparam logic [1:0] MODE_QUANT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PMULT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PER  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VGAIN    = 4'd7;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ET    = 5'd1;
    localparam logic [4:0] S_LOW   = 5'd2;
    localparam logic [4:0] S_BAND  = 5'd3;
    localparam logic [4:0] S_FUND  = 5'd4;
    localparam logic [4:0] S_VOIC  = 5'd5;
    localparam logic [4:0] S_OVER  = 5'd6;
    localparam logic [4:0] S_CROSS = 5'd7;
    localparam logic [4:0] S_FRAC  = 5'd8;
    localparam logic [4:0] S_MINB  = 5'd9;
    localparam logic [4:0] S_STEP  = 5'd10;
    localparam logic [4:0] S_BASE  = 5'd11;
    localparam logic [4:0] S_SDIV  = 5'd12;
    localparam logic [4:0] S_NORM  = 5'd13;
    localparam logic [4:0] S_SEMI  = 5'd14;
    localparam logic [4:0] S_SHIFT = 5'd15;
    localparam logic [4:0] S_NOISE = 5'd16;
    localparam logic [4:0] S_NSAW  = 5'd17;
    localparam logic [4:0] S_NBR   = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [4:0]           r_state, n_state;
    logic                 r_issued, n_issued;
    logic                 r_out_valid, n_out_valid;
    logic [SB-1:0]        r_voice_out, n_voice_out;
    logic [SB-1:0]        r_carrier_out, n_carrier_out;

    logic [1:0]           r_mode, n_mode;
    logic [18:0]          r_pmult, n_pmult;
    logic [22:0]          r_fixed, n_fixed;
    logic [15:0]          r_breath, n_breath;
    logic [20:0]          r_coef, n_coef;
    logic [19:0]          r_maxp, n_maxp;
    logic [16:0]          r_vgain, n_vgain;

    logic signed [31:0]   r_low, n_low;
    logic signed [31:0]   r_band, n_band;
    logic signed [31:0]   r_prev, n_prev;
    logic [PW-1:0]        r_pc, n_pc;
    logic [CW-1:0]        r_minb, n_minb;
    logic signed [31:0]   r_fund, n_fund;
    logic signed [31:0]   r_over, n_over;
    logic [23:0]          r_step, n_step;
    logic signed [24:0]   r_saw, n_saw;
    logic [15:0]          r_lfsr, n_lfsr;

    logic [SB-1:0]        r_raw, n_raw;
    logic signed [24:0]   r_a, n_a;
    logic [17:0]          r_et, n_et;
    logic [25:0]          r_bv, n_bv;
    logic [32:0]          r_den, n_den;
    logic [8:0]           r_frac, n_frac;
    logic [PW-1:0]        r_per, n_per;
    logic [23:0]          r_st, n_st;
    logic [34:0]          r_base, n_base;
    logic [63:0]          r_norm, n_norm;
    logic [5:0]           r_pos, n_pos;
    logic                 r_wrap, n_wrap;
    logic signed [27:0]   r_nz, n_nz;

    logic                 use_mul, use_div, fire;
    logic signed [36:0]   p_hi24;
    logic signed [44:0]   p_hi16;
    logic [44:0]          abs_bv;
    logic [35:0]          abs_low;
    logic [PW:0]          pc_sum;
    logic [PW-1:0]        pc_inc;
    logic                 crossing, in_range;
    logic signed [PW+1:0] per_full;
    logic [23:0]          q_sat;
    logic [3:0]           idx, sel;
    logic                 wrap;
    logic signed [7:0]    sh, nsh;
    logic [52:0]          v, v_shr;
    logic [23:0]          snapped;
    logic [15:0]          lfsr_nx;
    logic signed [15:0]   noise_k;
    logic signed [28:0]   car_sum, car_shift;
    logic [SB-1:0]        car;
    logic signed [25:0]   saw_sum;
    logic                 load_out;

    vcpt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    vcpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        p_hi24   = mul_rsp.p[60:24];
        p_hi16   = mul_rsp.p[60:16];
        abs_bv   = p_hi16[44] ? 45'(-p_hi16) : 45'(p_hi16);
        abs_low  = r_low[31] ? -36'(r_low) : 36'(r_low);
        pc_sum   = {1'b0, r_pc} + (PW+1)'(256);
        pc_inc   = (pc_sum > {1'b0, PMAX}) ? PMAX : pc_sum[PW-1:0];
        crossing = (r_band > 32'sd0) && (r_prev <= 32'sd0);
        in_range = (CW'(pc_inc) > r_minb) && (CW'(pc_inc) < CW'(r_maxp));
        per_full = $signed((PW+2)'(r_pc)) - $signed((PW+2)'(r_frac));
        q_sat    = (div_rsp.quo > 64'(STEP_MAX)) ? STEP_MAX : div_rsp.quo[23:0];
        idx      = semi_index(r_norm[63:47]);
        wrap     = (idx == 4'd12);
        sel      = wrap ? 4'd0 : idx;
        sh       = 8'sd52 - $signed({2'b00, r_pos}) - $signed({7'b0, r_wrap});
        nsh      = -sh;
        v        = r_norm[52:0];
        v_shr    = v >> sh[5:0];
        if (sh >= 8'sd63) begin
            snapped = '0;
        end else if (sh <= 8'sd0) begin
            if (v > (53'(STEP_MAX) >> nsh[5:0])) begin
                snapped = STEP_MAX;
            end else begin
                snapped = 24'(v << nsh[5:0]);
            end
        end else begin
            snapped = (v_shr > 53'(STEP_MAX)) ? STEP_MAX : v_shr[23:0];
        end
        lfsr_nx   = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'h0000);
        noise_k   = $signed({1'b0, lfsr_nx[14:0]}) - 16'sd16384;
        car_sum   = 29'(r_nz) + 29'(r_saw >>> 1);
        car_shift = car_sum >>> (24 - SB);
        if (car_shift > CAR_MAX) begin
            car = CAR_MAX[SB-1:0];
        end else if (car_shift < CAR_MIN) begin
            car = CAR_MIN[SB-1:0];
        end else begin
            car = car_shift[SB-1:0];
        end
        saw_sum = 26'(r_saw) + $signed({2'b00, r_step});
        if (saw_sum > 26'sd8388608) begin
            saw_sum = saw_sum - 26'sd16777216;
        end
    end

    assign fire     = r_issued && (mul_rsp.done || div_rsp.done);
    assign load_out = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state       = r_state;
        n_voice_out   = r_voice_out;
        n_carrier_out = r_carrier_out;
        n_mode        = r_mode;
        n_pmult       = r_pmult;
        n_fixed       = r_fixed;
        n_breath      = r_breath;
        n_coef        = r_coef;
        n_maxp        = r_maxp;
        n_vgain       = r_vgain;
        n_low         = r_low;
        n_band        = r_band;
        n_prev        = r_prev;
        n_pc          = r_pc;
        n_minb        = r_minb;
        n_fund        = r_fund;
        n_over        = r_over;
        n_step        = r_step;
        n_saw         = r_saw;
        n_lfsr        = r_lfsr;
        n_raw         = r_raw;
        n_a           = r_a;
        n_et          = r_et;
        n_bv          = r_bv;
        n_den         = r_den;
        n_frac        = r_frac;
        n_per         = r_per;
        n_st          = r_st;
        n_base        = r_base;
        n_norm        = r_norm;
        n_pos         = r_pos;
        n_wrap        = r_wrap;
        n_nz          = r_nz;
        use_mul       = 1'b0;
        use_div       = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        div_req.dvd   = '0;
        div_req.dvs   = '0;
        div_req.last  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_raw   = i_voice_sample;
                    n_a     = 25'($signed(i_voice_sample)) <<< (24 - SB);
                    n_state = S_ET;
                end
            end
            S_ET: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_coef);
                mul_req.b = 25'(ET_RECIP);
                if (fire) begin
                    n_et    = mul_rsp.p[ET_SHIFT +: 18];
                    n_state = S_LOW;
                end
            end
            S_LOW: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_band) + 36'(r_a);
                mul_req.b = 25'(r_coef);
                if (fire) begin
                    n_low   = sat32(40'(r_low) - 40'(p_hi24));
                    n_state = S_BAND;
                end
            end
            S_BAND: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_band) - 36'(r_low);
                mul_req.b = 25'(r_coef);
                if (fire) begin
                    n_band  = sat32(40'(r_band) - 40'(p_hi24));
                    n_state = S_FUND;
                end
            end
            S_FUND: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_fund) - $signed(abs_low);
                mul_req.b = 25'(r_et);
                if (fire) begin
                    n_fund  = sat32(40'(r_fund) - 40'(p_hi24));
                    n_state = S_VOIC;
                end
            end
            S_VOIC: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_a) + 36'(OFFSET_Q23);
                mul_req.b = 25'(r_vgain);
                if (fire) begin
                    n_bv    = abs_bv[25:0];
                    n_state = S_OVER;
                end
            end
            S_OVER: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_over) - $signed(36'(r_bv));
                mul_req.b = 25'(r_et);
                if (fire) begin
                    n_over  = sat32(40'(r_over) - 40'(p_hi24));
                    n_state = S_CROSS;
                end
            end
            S_CROSS: begin
                n_pc    = pc_inc;
                n_state = S_NOISE;
                if (r_mode == MODE_FIXED) begin
                    n_step = {1'b0, r_fixed};
                end else begin
                    n_prev = r_band;
                    n_den  = 33'(33'(r_band) - 33'(r_prev));
                    if (crossing) begin
                        if (in_range) begin
                            n_state = S_FRAC;
                        end else begin
                            n_pc = '0;
                        end
                    end
                end
            end
            S_FRAC: begin
                use_div      = 1'b1;
                div_req.dvd  = {r_band, 32'b0};
                div_req.dvs  = 36'(r_den);
                div_req.last = 6'd39;
                if (fire) begin
                    n_frac  = div_rsp.quo[8:0];
                    n_state = S_MINB;
                end
            end
            S_MINB: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_pc);
                mul_req.b = 25'(SIXTENTHS);
                n_per     = (per_full < (PW+2)'(1)) ? PW'(1) : per_full[PW-1:0];
                if (fire) begin
                    n_minb  = CW'(mul_rsp.p[16 +: PW]);
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                use_div      = 1'b1;
                div_req.dvd  = {r_pmult, 45'b0};
                div_req.dvs  = 36'(r_per);
                div_req.last = 6'd34;
                if (fire) begin
                    n_pc = PW'(r_frac);
                    if (r_mode == MODE_QUANT && q_sat != '0 && r_coef != '0) begin
                        n_st    = q_sat;
                        n_state = S_BASE;
                    end else begin
                        n_step  = q_sat;
                        n_state = S_NOISE;
                    end
                end
            end
            S_BASE: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_coef);
                mul_req.b = 25'(ROOT_K);
                if (fire) begin
                    n_base  = mul_rsp.p[34:0];
                    n_state = S_SDIV;
                end
            end
            S_SDIV: begin
                use_div      = 1'b1;
                div_req.dvd  = {r_st, 40'b0};
                div_req.dvs  = 36'(r_base);
                div_req.last = 6'd59;
                if (fire) begin
                    if (div_rsp.quo == '0) begin
                        n_step  = '0;
                        n_state = S_NOISE;
                    end else begin
                        n_norm  = div_rsp.quo;
                        n_pos   = 6'd63;
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (r_norm[63]) begin
                    n_state = S_SEMI;
                end else begin
                    n_norm = r_norm << 1;
                    n_pos  = r_pos - 6'd1;
                end
            end
            S_SEMI: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_base);
                mul_req.b = 25'(semi_ratio(sel));
                if (fire) begin
                    n_wrap  = wrap;
                    n_norm  = 64'(mul_rsp.p[52:0]);
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_step  = snapped;
                n_state = S_NOISE;
            end
            S_NOISE: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(noise_k);
                mul_req.b = 25'(NOISE_SCALE);
                if (fire) begin
                    n_lfsr  = lfsr_nx;
                    n_nz    = mul_rsp.p[43:16];
                    n_state = (r_fund > r_over) ? S_NSAW : S_OUT;
                end
            end
            S_NSAW: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_nz);
                mul_req.b = r_saw;
                if (fire) begin
                    n_nz    = mul_rsp.p[51:24];
                    n_state = S_NBR;
                end
            end
            S_NBR: begin
                use_mul   = 1'b1;
                mul_req.a = 36'(r_nz);
                mul_req.b = 25'(r_breath);
                if (fire) begin
                    n_nz    = mul_rsp.p[40:13];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_voice_out   = r_raw;
                    n_carrier_out = car;
                    n_saw         = saw_sum[24:0];
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:    n_mode   = i_cfg_data[1:0];
                CFG_PMULT:   n_pmult  = i_cfg_data[18:0];
                CFG_FIXED:   n_fixed  = i_cfg_data[22:0];
                CFG_BREATH:  n_breath = i_cfg_data[15:0];
                CFG_COEF:    n_coef   = i_cfg_data[20:0];
                CFG_MIN_PER: n_minb   = CW'(i_cfg_data[19:0]);
                CFG_MAX_PER: n_maxp   = i_cfg_data[19:0];
                CFG_VGAIN:   n_vgain  = i_cfg_data[16:0];
                default:     n_mode   = r_mode;
            endcase
        end

        mul_req.start = use_mul && !r_issued;
        div_req.start = use_div && !r_issued;
    end

    assign n_issued      = (use_mul || use_div) ? (r_issued ? !fire : 1'b1) : 1'b0;
    assign n_out_valid   = load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 2'd0;
            r_pmult     <= 19'd65536;
            r_fixed     <= 23'd38448;
            r_breath    <= 16'd9830;
            r_coef      <= 21'd230687;
            r_maxp      <= 20'd368640;
            r_vgain     <= 17'd16384;
            r_low       <= '0;
            r_band      <= '0;
            r_prev      <= '0;
            r_pc        <= '0;
            r_minb      <= CW'(42330);
            r_fund      <= '0;
            r_over      <= '0;
            r_step      <= '0;
            r_saw       <= '0;
            r_lfsr      <= LFSR_SEED;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_pmult     <= n_pmult;
            r_fixed     <= n_fixed;
            r_breath    <= n_breath;
            r_coef      <= n_coef;
            r_maxp      <= n_maxp;
            r_vgain     <= n_vgain;
            r_low       <= n_low;
            r_band      <= n_band;
            r_prev      <= n_prev;
            r_pc        <= n_pc;
            r_minb      <= n_minb;
            r_fund      <= n_fund;
            r_over      <= n_over;
            r_step      <= n_step;
            r_saw       <= n_saw;
            r_lfsr      <= n_lfsr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_voice_out   <= n_voice_out;
        r_carrier_out <= n_carrier_out;
        r_raw         <= n_raw;
        r_a           <= n_a;
        r_et          <= n_et;
        r_bv          <= n_bv;
        r_den         <= n_den;
        r_frac        <= n_frac;
        r_per         <= n_per;
        r_st          <= n_st;
        r_base        <= n_base;
        r_norm        <= n_norm;
        r_pos         <= n_pos;
        r_wrap        <= n_wrap;
        r_nz          <= n_nz;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_voice_out   = r_voice_out;
    assign o_carrier_out = r_carrier_out;

endmodule

### design/vcpt_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
module vcpt_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vcpt_pkg::t_mul_req i_req,
    output vcpt_pkg::t_mul_rsp o_rsp
);
    import vcpt_pkg::*;

    localparam int CW = $clog2(MUL_B_W);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic signed [MUL_P_W-1:0] r_acc, n_acc;
    logic signed [MUL_P_W-1:0] r_mcand, n_mcand;
    logic        [MUL_B_W-1:0] r_mplier, n_mplier;
    logic        [CW-1:0]      r_cnt, n_cnt;
    logic                      last;

    assign last = (r_cnt == CW'(MUL_B_W - 1));

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_acc    = '0;
            n_mcand  = MUL_P_W'($signed(i_req.a));
            n_mplier = i_req.b;
            n_cnt    = '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = last ? r_acc - r_mcand : r_acc + r_mcand;
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + CW'(1);
            if (last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

### design/vcpt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module vcpt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vcpt_pkg::t_div_req i_req,
    output vcpt_pkg::t_div_rsp o_rsp
);
    import vcpt_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DIV_D_W:0]   r_rem, n_rem;
    logic [DIV_N_W-1:0] r_dvd, n_dvd;
    logic [DIV_N_W-1:0] r_quo, n_quo;
    logic [DIV_D_W-1:0] r_dvs, n_dvs;
    logic [DIV_C_W-1:0] r_cnt, n_cnt;
    logic [DIV_D_W:0]   trial;
    logic               ge;

    assign trial = {r_rem[DIV_D_W-1:0], r_dvd[DIV_N_W-1]};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_rem  = '0;
            n_dvd  = i_req.dvd;
            n_quo  = '0;
            n_dvs  = i_req.dvs;
            n_cnt  = i_req.last;
        end else if (r_busy) begin
            n_rem = ge ? trial - {1'b0, r_dvs} : trial;
            n_quo = {r_quo[DIV_N_W-2:0], ge};
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt - DIV_C_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

### sim/vocoder_carrier_pitch_tracker_test.sv
// Testbench for the vocoder carrier pitch tracker: random and directed samples, scoreboard check.
module vocoder_carrier_pitch_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     IDLE_PCT   = 11;
    localparam int     SETTLE     = 700;
    localparam int     PHASES     = 12;
    localparam int     PER_PHASE  = 105;
    localparam longint CYCLE_CAP  = 5000000;

    typedef enum int {
        REG_MODE = 0, REG_PITCH_MULT = 1, REG_FIXED_STEP = 2, REG_BREATH_GAIN = 3,
        REG_FILTER_COEF = 4, REG_MIN_PERIOD = 5, REG_MAX_PERIOD = 6, REG_VOICING_GAIN = 7,
        REG_UNUSED = 9
    } t_reg_index;

    typedef enum logic [1:0] {
        MODE_FIXED = 2'd0, MODE_FREE = 2'd1, MODE_QUANT = 2'd2, MODE_SPARE = 2'd3
    } t_track_mode;

    class carrier_board;
        int unsigned errors;
        logic [15:0] voice_due[$];
        logic [15:0] carrier_due[$];
        logic [1:0]  mode;
        logic [18:0] pitch_mult;
        logic [22:0] fixed_step;
        logic [15:0] breath_gain;
        logic [20:0] filter_coef;
        logic [19:0] min_period, max_period;
        logic [16:0] voicing_gain;
        longint low, band, prev_band, count, min_bnd, fund, overall, step, phase;
        logic [15:0] lfsr;
        longint semis[12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                              92682, 98193, 104032, 110218, 116772, 123715};
        longint edges[12] = '{67456, 71468, 75717, 80220, 84990, 90043,
                              95398, 101070, 107080, 113448, 120194, 127341};

        function new();
            errors = 0;
            mode = MODE_FIXED;
            pitch_mult = 65536;
            fixed_step = 38448;
            breath_gain = 9830;
            filter_coef = 230687;
            min_period = 42330;
            max_period = 368640;
            voicing_gain = 16384;
            low = 0; band = 0; prev_band = 0; count = 0;
            min_bnd = min_period;
            fund = 0; overall = 0; step = 0; phase = 0;
            lfsr = 16'hACE1;
        endfunction

        function void write_reg(int idx, logic [31:0] v);
            case (idx)
                REG_MODE:         mode = v[1:0];
                REG_PITCH_MULT:   pitch_mult = v[18:0];
                REG_FIXED_STEP:   fixed_step = v[22:0];
                REG_BREATH_GAIN:  breath_gain = v[15:0];
                REG_FILTER_COEF:  filter_coef = v[20:0];
                REG_MIN_PERIOD: begin
                    min_period = v[19:0];
                    min_bnd = min_period;
                end
                REG_MAX_PERIOD:   max_period = v[19:0];
                REG_VOICING_GAIN: voicing_gain = v[16:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint x, longint lo, longint hi);
            return x < lo ? lo : (x > hi ? hi : x);
        endfunction

        function longint clamp32(longint x);
            return clamp(x, -64'sd2147483648, 64'sd2147483647);
        endfunction

        function longint magnitude(longint x);
            return x < 0 ? -x : x;
        endfunction

        function longint snap_step(longint s);
            longint unsigned base, r, m, v;
            int p, o, n, sh;
            base = longint'(filter_coef) * 12989;
            p = 63;
            n = 0;
            if (s <= 0 || base == 0) return s;
            r = (longint'(s) << 36) / base;
            if (r == 0) return 0;
            while (r[p] == 1'b0) p--;
            o = p - 16;
            m = p >= 16 ? r >> (p - 16) : r << (16 - p);
            for (int j = 0; j < 12; j++)
                if (m >= edges[j]) n++;
            if (n == 12) begin
                n = 0;
                o++;
            end
            v = base * semis[n];
            sh = 36 - o;
            if (sh >= 63) return 0;
            if (sh <= 0) begin
                if (v > (longint'(24'hFFFFFF) >> (-sh))) return 24'hFFFFFF;
                v = v << (-sh);
            end else begin
                v = v >> sh;
            end
            return v > 24'hFFFFFF ? 24'hFFFFFF : longint'(v);
        endfunction

        function void note_sample(logic [15:0] s);
            longint x, a, lf, et, vg, bg, b, nz, noise, car, frac, per, st;
            logic lsb;
            x = $signed(s);
            a = x * 256;
            lf = filter_coef;
            et = lf / 10;
            vg = voicing_gain;
            bg = breath_gain;
            low = clamp32(low - ((lf * (band + a)) >>> 24));
            band = clamp32(band - ((lf * (band - low)) >>> 24));
            fund = clamp32(fund - ((et * (fund - magnitude(low))) >>> 24));
            b = magnitude(((a + 251658) * vg) >>> 16);
            overall = clamp32(overall - ((et * (overall - b)) >>> 24));
            count = count + 256 > 1048575 ? 1048575 : count + 256;
            if (mode == MODE_FIXED) begin
                step = fixed_step;
            end else begin
                if (band > 0 && prev_band <= 0) begin
                    if (count > min_bnd && count < longint'(max_period)) begin
                        frac = (band * 256) / (band - prev_band);
                        per = count - frac;
                        min_bnd = (count * 39322) >>> 16;
                        if (per < 1) per = 1;
                        st = (longint'(pitch_mult) << 16) / per;
                        if (st > 24'hFFFFFF) st = 24'hFFFFFF;
                        if (mode == MODE_QUANT) st = snap_step(st);
                        step = st;
                        count = frac;
                    end else begin
                        count = 0;
                    end
                end
                prev_band = band;
            end
            lsb = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb) lfsr = lfsr ^ 16'hB400;
            noise = lfsr & 16'h7FFF;
            nz = ((noise - 16384) * 5497558) >>> 16;
            if (fund > overall) nz = (((nz * phase) >>> 24) * bg) >>> 13;
            b = nz + (phase >>> 1);
            phase = phase + step;
            if (phase > 8388608) phase = phase - 16777216;
            car = clamp(b >>> 8, -32768, 32767);
            voice_due.push_back(s);
            carrier_due.push_back(car[15:0]);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_word(logic [15:0] voice, logic [15:0] carrier);
            logic [15:0] ev, ec;
            if (voice_due.size() == 0) begin
                report($sformatf("unexpected word voice=%h carrier=%h", voice, carrier));
                return;
            end
            ev = voice_due.pop_front();
            ec = carrier_due.pop_front();
            if (voice !== ev) report($sformatf("voice got %h want %h", voice, ev));
            if (carrier !== ec) report($sformatf("carrier got %h want %h", carrier, ec));
        endtask

        function int pending();
            return voice_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_voice_sample;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_voice_out;
    logic [15:0] o_carrier_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [vcpt_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [vcpt_pkg::CFG_DATA_W-1:0] i_cfg_data;

    carrier_board board;
    bit     quiet;
    bit     hold;
    longint cycles;

    vocoder_carrier_pitch_tracker u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_voice_sample (i_voice_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_voice_out    (o_voice_out),
        .o_carrier_out  (o_carrier_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= !hold && (quiet || $urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_word(o_voice_out, o_carrier_out);
    end

    task automatic send_sample(input logic [15:0] s);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_voice_sample <= s;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(s);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[vcpt_pkg::CFG_IDX_W-1:0];
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic configure(input int ph);
        write_reg(REG_MODE, ph % 4);
        write_reg(REG_PITCH_MULT, ph == 1 ? 16384 : ph == 2 ? 262144
                                  : $urandom_range(262144, 16384));
        write_reg(REG_FIXED_STEP, ph == 4 ? 0 : ph == 8 ? 8388607
                                  : $urandom_range(8388607));
        write_reg(REG_BREATH_GAIN, ph == 5 ? 0 : ph == 6 ? 49152 : $urandom_range(49152));
        write_reg(REG_FILTER_COEF, ph == 10 ? 0 : ph == 9 ? 1677721
                                   : $urandom_range(600000, 60000));
        write_reg(REG_MIN_PERIOD, ph == 3 ? 256 : ph == 7 ? 1048575
                                  : $urandom_range(256 * 30, 256));
        write_reg(REG_MAX_PERIOD, ph == 5 ? 256 : ph == 11 ? 1048575
                                  : $urandom_range(1048575, 256 * 60));
        write_reg(REG_VOICING_GAIN, ph == 2 ? 0 : ph == 6 ? 65536 : $urandom_range(65536));
        write_reg(REG_UNUSED, $urandom);
    endtask

    task automatic run_voice(input int items);
        int left, seg, per, amp, k;
        bit tone;
        logic [15:0] s;
        left = items;
        while (left > 0) begin
            seg  = $urandom_range(60, 30);
            tone = $urandom_range(99) < 80;
            per  = $urandom_range(120, 8);
            amp  = $urandom_range(32767, 2000);
            for (k = 0; k < seg && left > 0; k++) begin
                if (tone) begin
                    s = 16'(((k % per) < per / 2 ? amp : -amp)
                            + $signed($urandom_range(511)) - 256);
                end else begin
                    s = 16'($urandom);
                end
                send_sample(s);
                left--;
            end
        end
    endtask

    initial begin
        logic [15:0] edge_cases[10];
        edge_cases     = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                           16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h7FFF};
        board          = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_voice_sample = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        quiet          = 1'b0;
        hold           = 1'b0;
        cycles         = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (edge_cases[i]) send_sample(edge_cases[i]);
        drain();
        write_reg(REG_MODE, MODE_QUANT);
        write_reg(REG_MIN_PERIOD, 256 * 4);
        for (int i = 0; i < 12; i++) send_sample(i % 6 < 3 ? 16'h7FFF : 16'h8000);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            configure(ph);
            quiet = (ph == 7);
            if (ph == 3) begin
                fork
                    begin
                        hold = 1'b1;
                        repeat (3000) @(negedge i_clk);
                        hold = 1'b0;
                    end
                join_none
            end
            run_voice(PER_PHASE);
            drain();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
design/vcpt_pkg.sv
design/vcpt_mul.sv
design/vcpt_div.sv
design/vocoder_carrier_pitch_tracker.sv
sim/vocoder_carrier_pitch_tracker_test.sv
